@@ rtl/pfe_pkg.sv @@
// Shared constants and controller/datapath interface types for the postfix evaluator.
package pfe_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DATA_W      = 32;
    localparam int SYM_W       = 8;
    localparam int ERR_W       = 3;
    localparam int DIV_CNT_W   = $clog2(DATA_W + 1);
    localparam int OUT_TDATA_W = ((DATA_W + ERR_W + 7) / 8) * 8;

    localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
    localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 3'd1;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 3'd2;
    localparam logic [ERR_W-1:0] ERR_DIVZERO   = 3'd3;
    localparam logic [ERR_W-1:0] ERR_UNKNOWN   = 3'd4;

    localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [SYM_W-1:0] CH_NINE  = 8'h39;
    localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;

    typedef struct packed {
        logic load_in;
        logic push_digit;
        logic push_result;
        logic pop;
        logic cap_rhs;
        logic cap_lhs;
        logic flag_unknown;
        logic exec;
        logic div_fix;
        logic read_top;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic is_digit;
        logic is_op;
        logic is_div;
        logic rhs_zero;
        logic last;
        logic div_busy;
        logic out_free;
    } dp_status_t;

endpackage

@@ rtl/pfe_ctrl.sv @@
// Sequencing state machine for the postfix evaluator.
module pfe_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  pfe_pkg::dp_status_t status,
    output pfe_pkg::dp_cmd_t    cmd
);
    import pfe_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DECODE = 4'd1;
    localparam logic [3:0] ST_POP2   = 4'd2;
    localparam logic [3:0] ST_GETL   = 4'd3;
    localparam logic [3:0] ST_EXEC   = 4'd4;
    localparam logic [3:0] ST_DIVW   = 4'd5;
    localparam logic [3:0] ST_PUSH   = 4'd6;
    localparam logic [3:0] ST_FIN    = 4'd7;
    localparam logic [3:0] ST_OUT    = 4'd8;

    logic [3:0] state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (status.is_digit) begin
                    cmd.push_digit = 1'b1;
                    state_next     = ST_FIN;
                end else if (status.is_op) begin
                    cmd.pop    = 1'b1;
                    state_next = ST_POP2;
                end else begin
                    cmd.flag_unknown = 1'b1;
                    state_next       = ST_FIN;
                end
            end
            ST_POP2: begin
                cmd.cap_rhs = 1'b1;
                cmd.pop     = 1'b1;
                state_next  = ST_GETL;
            end
            ST_GETL: begin
                cmd.cap_lhs = 1'b1;
                state_next  = ST_EXEC;
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                if (status.is_div && !status.rhs_zero) begin
                    state_next = ST_DIVW;
                end else begin
                    state_next = ST_PUSH;
                end
            end
            ST_DIVW: begin
                if (!status.div_busy) begin
                    cmd.div_fix = 1'b1;
                    state_next  = ST_PUSH;
                end
            end
            ST_PUSH: begin
                cmd.push_result = 1'b1;
                state_next      = ST_FIN;
            end
            ST_FIN: begin
                if (status.last) begin
                    cmd.read_top = 1'b1;
                    state_next   = ST_OUT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                // hold until the output register is free
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/pfe_dp.sv @@
// Datapath: operand stack memory, ALU, iterative divider and result register.
module pfe_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  pfe_pkg::dp_cmd_t                    cmd,
    output pfe_pkg::dp_status_t                 status,
    input  logic [pfe_pkg::SYM_W-1:0]           in_symbol,
    input  logic                                in_last,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pfe_pkg::OUT_TDATA_W-1:0]     m_tdata
);
    import pfe_pkg::*;

    logic [DATA_W-1:0]    stack_mem [STACK_DEPTH];

    logic [SYM_W-1:0]     symbol_reg;
    logic                 last_reg;
    logic [LEVEL_W-1:0]   level_reg, level_next;
    logic [ERR_W-1:0]     sticky_reg, sticky_next;
    logic                 pop_ok_reg, pop_ok_next;
    logic [DATA_W-1:0]    rd_data_reg;
    logic [DATA_W-1:0]    rhs_reg, lhs_reg;
    logic [DATA_W-1:0]    result_reg, result_next;
    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [DATA_W-1:0]    quo_reg, quo_next;
    logic [DATA_W-1:0]    dvsr_reg, dvsr_next;
    logic                 neg_reg, neg_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DATA_W-1:0]    value_reg;
    logic [ERR_W-1:0]     error_reg;
    logic                 m_tvalid_reg;

    logic                 wr_en, rd_en;
    logic [ADDR_W-1:0]    wr_addr, rd_addr;
    logic [DATA_W-1:0]    wr_data;
    logic [ERR_W-1:0]     flag_code;
    logic [LEVEL_W-1:0]   level_dec;
    logic                 stack_full;
    logic [SYM_W-1:0]     digit_val;
    logic [DATA_W-1:0]    operand;
    logic [DATA_W:0]      div_shift, div_diff;
    logic                 is_digit, is_op, is_div;

    assign is_digit   = (symbol_reg >= CH_ZERO) && (symbol_reg <= CH_NINE);
    assign is_div     = (symbol_reg == CH_SLASH);
    assign is_op      = (symbol_reg == CH_PLUS) || (symbol_reg == CH_MINUS) ||
                        (symbol_reg == CH_STAR) || is_div;
    assign level_dec  = level_reg - 1'b1;
    assign stack_full = (level_reg == LEVEL_W'(STACK_DEPTH));
    assign digit_val  = symbol_reg - CH_ZERO;
    // a pop of an empty stack reads as zero
    assign operand    = pop_ok_reg ? rd_data_reg : '0;
    assign div_shift  = {rem_reg, quo_reg[DATA_W-1]};
    assign div_diff   = div_shift - {1'b0, dvsr_reg};

    assign status.is_digit = is_digit;
    assign status.is_op    = is_op;
    assign status.is_div   = is_div;
    assign status.rhs_zero = (rhs_reg == '0);
    assign status.last     = last_reg;
    assign status.div_busy = (cnt_reg != '0);
    assign status.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - DATA_W - ERR_W){1'b0}}, error_reg, value_reg};

    always_comb begin
        level_next  = level_reg;
        sticky_next = sticky_reg;
        pop_ok_next = pop_ok_reg;
        result_next = result_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        dvsr_next   = dvsr_reg;
        neg_next    = neg_reg;
        cnt_next    = cnt_reg;
        wr_en       = 1'b0;
        wr_addr     = level_reg[ADDR_W-1:0];
        wr_data     = result_reg;
        rd_en       = 1'b0;
        rd_addr     = level_dec[ADDR_W-1:0];
        flag_code   = ERR_NONE;

        if (cmd.push_digit || cmd.push_result) begin
            wr_data = cmd.push_digit ? {{(DATA_W - SYM_W){1'b0}}, digit_val} : result_reg;
            if (stack_full) begin
                flag_code = ERR_OVERFLOW;
            end else begin
                wr_en      = 1'b1;
                level_next = level_reg + 1'b1;
            end
        end

        if (cmd.pop) begin
            if (level_reg == '0) begin
                flag_code   = ERR_UNDERFLOW;
                pop_ok_next = 1'b0;
            end else begin
                rd_en       = 1'b1;
                level_next  = level_dec;
                pop_ok_next = 1'b1;
            end
        end

        if (cmd.read_top) begin
            rd_en       = (level_reg != '0);
            pop_ok_next = (level_reg != '0);
        end

        if (cmd.flag_unknown) begin
            flag_code = ERR_UNKNOWN;
        end

        if (cmd.exec) begin
            if (symbol_reg == CH_PLUS) begin
                result_next = lhs_reg + rhs_reg;
            end else if (symbol_reg == CH_MINUS) begin
                result_next = lhs_reg - rhs_reg;
            end else if (symbol_reg == CH_STAR) begin
                result_next = lhs_reg * rhs_reg;
            end else if (rhs_reg == '0) begin
                flag_code   = ERR_DIVZERO;
                result_next = '0;
            end else begin
                // start magnitude division
                neg_next  = lhs_reg[DATA_W-1] ^ rhs_reg[DATA_W-1];
                quo_next  = lhs_reg[DATA_W-1] ? (~lhs_reg + 1'b1) : lhs_reg;
                dvsr_next = rhs_reg[DATA_W-1] ? (~rhs_reg + 1'b1) : rhs_reg;
                rem_next  = '0;
                cnt_next  = DIV_CNT_W'(DATA_W);
            end
        end

        // one restoring quotient bit per cycle
        if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
            if (!div_diff[DATA_W]) begin
                rem_next = div_diff[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end else begin
                rem_next = div_shift[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
        end

        if (cmd.div_fix) begin
            result_next = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
        end

        // keep only the first error since the last clear
        if ((flag_code != ERR_NONE) && (sticky_reg == ERR_NONE)) begin
            sticky_next = flag_code;
        end

        if (cmd.load_out) begin
            level_next  = '0;
            sticky_next = ERR_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stack_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            symbol_reg <= in_symbol;
            last_reg   <= in_last;
        end
        if (cmd.cap_rhs) begin
            rhs_reg <= operand;
        end
        if (cmd.cap_lhs) begin
            lhs_reg <= operand;
        end
        if (cmd.load_out) begin
            value_reg <= operand;
            error_reg <= sticky_reg;
        end
        pop_ok_reg <= pop_ok_next;
        result_reg <= result_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        dvsr_reg   <= dvsr_next;
        neg_reg    <= neg_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg    <= '0;
            sticky_reg   <= ERR_NONE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            level_reg  <= level_next;
            sticky_reg <= sticky_next;
            cnt_reg    <= cnt_next;
            if (cmd.load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

endmodule

@@ rtl/postfix_expression_evaluator.sv @@
// Top level of the postfix expression evaluator: controller plus datapath.
//
//  Channel | Direction | Handshake          | Payload
//  s_      | in        | s_tvalid/s_tready  | s_tdata[7:0] symbol, s_tlast last
//  m_      | out       | m_tvalid/m_tready  | m_tdata[31:0] value, [34:32] error
//
// One symbol at a time. A digit is pushed and an unknown symbol flagged; + - * pop
// two operands and push the result. Divide uses the 32-step bit-serial divider.
// A last symbol then reads the top of the 64-entry stack memory for the output.
// Synchronous active-low reset clears the stack level and the error; no sweep.
// A stalled m_ side holds the result register; the next symbol is still taken
// and only a further last symbol waits for the register to free.
module postfix_expression_evaluator (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [pfe_pkg::SYM_W-1:0]           s_tdata,   // [7:0] symbol
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pfe_pkg::OUT_TDATA_W-1:0]     m_tdata    // [31:0] value, [34:32] error
);
    import pfe_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    pfe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pfe_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .in_symbol (s_tdata),
        .in_last   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
